// File: design/sitoa_pkg.sv
// shared constants and types for the signed integer to decimal text converter
package sitoa_pkg;

   // width of the signed input value
   localparam int VALUE_WIDTH = 32;

   // decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1)
   localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

   // counter widths
   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam int REM_W = $clog2(NUM_DIGITS + 1);
   localparam int CHR_W = ($clog2(NUM_DIGITS + 2) > 4) ? $clog2(NUM_DIGITS + 2) : 4;

   // output field widths
   localparam int CODE_W  = 6;
   localparam int COUNT_W = 4;

   // character codes
   localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;

   // per-cycle command to every digit cell
   typedef struct packed {
      logic clear;   // zero the digit
      logic dabble;  // add-3 correction then shift one bit in
      logic move;    // take the lower neighbor's whole digit
   } cell_ctrl_type;

endpackage

// File: design/sitoa_cell.sv
// one bcd digit cell of the double-dabble chain
module sitoa_cell
   import sitoa_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          carry_bit,
   input  logic [3:0]    lower_digit,
   output logic [3:0]    digit,
   output logic          bit_out
);

   logic [3:0] digit_ff;
   logic [3:0] digit_in;
   logic [3:0] adjusted;

   // add 3 when the digit would overflow past 9 after doubling
   assign adjusted = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign bit_out  = adjusted[3];
   assign digit    = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in = 4'd0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[2:0], carry_bit};
      end else if (ctrl.move) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// File: design/signed_int_to_decimal_ascii.sv
// signed integer to decimal ascii text converter, top level
//
//   channel | direction | ports                                        | per request
//   req     | in        | req_valid req_ready req_value                | one integer
//   rsp     | out       | rsp_valid rsp_ready rsp_char_code rsp_last   | one character
//           |           | rsp_char_count                               |
//
// sequence: one request occupies the converter for a step that clears the digit chain,
//   then double-dabble steps (one bit shifted through the chain per cycle), then one
//   digit move per digit position, with a minus sign emitted first for a negative value
// reset: synchronous, active high, returns the controller to idle and drops rsp_valid
// stalls: a character waits in the output register while the chain holds its
//   digits; the final character can wait there while the next request is taken
module signed_int_to_decimal_ascii
   import sitoa_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CODE_W-1:0]             rsp_char_code,
   output logic                          rsp_last,
   output logic [COUNT_W-1:0]            rsp_char_count
);

   // controller states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   localparam logic [VALUE_WIDTH-1:0] ONE_VALUE = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

   state_type            state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     conv_cnt_ff, conv_cnt_in;
   logic [REM_W-1:0]     remain_ff, remain_in;
   logic [CHR_W-1:0]     chars_ff, chars_in;
   logic                 seen_ff, seen_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [VALUE_WIDTH-1:0] req_mag;
   logic                 out_free;
   logic                 accept;
   logic                 leading;
   logic [CHR_W-1:0]     chars_total;
   logic [3:0]           top_digit;
   cell_ctrl_type        ctrl;

   logic [3:0]           digit   [NUM_DIGITS];
   logic                 bit_out [NUM_DIGITS];

   // magnitude as unsigned: the most negative value wraps to itself, which is correct
   assign req_mag = req_value[VALUE_WIDTH-1] ? ((~$unsigned(req_value)) + ONE_VALUE)
                                             : $unsigned(req_value);

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign top_digit   = digit[NUM_DIGITS-1];
   // first nonzero digit, or the units digit of a zero
   assign leading     = seen_ff || (top_digit != 4'd0) || (remain_ff == REM_W'(1));
   assign chars_total = chars_ff + CHR_W'(1);

   // row of digit cells, lowest digit at index 0
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         sitoa_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .carry_bit   (mag_ff[VALUE_WIDTH-1]),
            .lower_digit (4'd0),
            .digit       (digit[i]),
            .bit_out     (bit_out[i])
         );
      end else begin : g_rest
         sitoa_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .carry_bit   (bit_out[i-1]),
            .lower_digit (digit[i-1]),
            .digit       (digit[i]),
            .bit_out     (bit_out[i])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      conv_cnt_in  = conv_cnt_ff;
      remain_in    = remain_ff;
      chars_in     = chars_ff;
      seen_in      = seen_ff;
      ctrl         = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in      = req_mag;
               neg_in      = req_value[VALUE_WIDTH-1];
               conv_cnt_in = '0;
               seen_in     = 1'b0;
               ctrl.clear  = 1'b1;
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            // one magnitude bit into the chain per cycle
            ctrl.dabble = 1'b1;
            mag_in      = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            conv_cnt_in = conv_cnt_ff + CNT_W'(1);
            if (conv_cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
               remain_in = REM_W'(NUM_DIGITS);
               chars_in  = '0;
               state_in  = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_count_in = '0;
               chars_in     = CHR_W'(1);
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (!leading) begin
               // leading zero: move up without emitting
               ctrl.move = 1'b1;
               remain_in = remain_ff - REM_W'(1);
            end else if (out_free) begin
               ctrl.move    = 1'b1;
               remain_in    = remain_ff - REM_W'(1);
               chars_in     = chars_total;
               seen_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_code_in  = CHAR_ZERO + {2'b00, top_digit};
               if (remain_ff == REM_W'(1)) begin
                  rsp_last_in  = 1'b1;
                  rsp_count_in = chars_total[COUNT_W-1:0];
                  state_in     = ST_IDLE;
               end else begin
                  rsp_last_in  = 1'b0;
                  rsp_count_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      conv_cnt_ff  <= conv_cnt_in;
      remain_ff    <= remain_in;
      chars_ff     <= chars_in;
      seen_ff      <= seen_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = rsp_code_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_char_count = rsp_count_ff;

   // a taken request always starts the bit-serial conversion
   a_accept_to_conv: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CONV))
      else $error("request accepted but conversion did not start");

   // digit phase never runs past the units digit
   a_remain_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (remain_ff != '0))
      else $error("digit phase with no digits left");

   // count appears only on the final character
   a_count_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_char_count != '0))
      else $error("final character without a count");

   a_count_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_char_count == '0))
      else $error("count on a non-final character");

   // only a minus sign or a decimal digit is emitted
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_char_code == CHAR_MINUS) ||
                     ((rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_ZERO + 6'd9))))
      else $error("character code out of range");

endmodule
